@@ design/mix_arithmetic_unit_defines.svh @@
// assertion macros for the mix arithmetic unit
// used by files that carry concurrent checks; expects clk_i and rst_ni in scope
`ifndef MIX_ARITHMETIC_UNIT_DEFINES_SVH
`define MIX_ARITHMETIC_UNIT_DEFINES_SVH

// same-cycle implication
`define MAU_ASSERT_NOW(lbl, pre, post, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (pre) |-> (post)) \
    else $error(msg);

// next-cycle implication
`define MAU_ASSERT_NEXT(lbl, pre, post, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (pre) |=> (post)) \
    else $error(msg);

`endif

@@ design/mau_pkg.sv @@
// shared constants and types for the mix arithmetic unit
// no dependencies
package mau_pkg;

  localparam int WORD_BYTES = 5;
  localparam int BYTE_BITS  = 8;
  localparam int MAG_BITS   = WORD_BYTES * BYTE_BITS;
  localparam int FIELD_BITS = 3;

  typedef logic [MAG_BITS-1:0] mag_t;

  typedef enum logic [1:0] {
    OP_ADD = 2'd0,
    OP_SUB = 2'd1,
    OP_MUL = 2'd2,
    OP_DIV = 2'd3
  } op_e;

  typedef enum logic [1:0] {
    MODE_PASS = 2'd0,
    MODE_MUL  = 2'd1,
    MODE_DIV  = 2'd2
  } mode_e;

  // one in-flight transaction as it walks the cell chain
  typedef struct packed {
    mode_e mode;
    mag_t  hi;      // partial product high half / remainder / new A
    mag_t  lo;      // multiplier, then product low half / dividend low, then quotient / new X
    mag_t  v;       // operand magnitude
    logic  a_sign;
    logic  x_sign;
    logic  ovf;
  } cell_t;

endpackage

@@ design/mau_front.sv @@
// operand extraction, add/subtract and invalid-case detection
// depends on mau_pkg
module mau_front (
  input  logic [1:0]                    op_i,
  input  logic [mau_pkg::FIELD_BITS-1:0] field_left_i,
  input  logic [mau_pkg::FIELD_BITS-1:0] field_right_i,
  input  logic                          acc_sign_i,
  input  mau_pkg::mag_t                 acc_mag_i,
  input  logic                          ext_sign_i,
  input  mau_pkg::mag_t                 ext_mag_i,
  input  logic                          mem_sign_i,
  input  mau_pkg::mag_t                 mem_mag_i,
  output mau_pkg::cell_t                cell_o
);

  logic [mau_pkg::FIELD_BITS-1:0] lo_byte;
  mau_pkg::mag_t                  field_mask;
  mau_pkg::mag_t                  vm;
  logic [mau_pkg::MAG_BITS-1:0]   shamt;
  logic                           vs;
  logic                           bad_field;
  logic                           eff_sign;
  logic [mau_pkg::MAG_BITS:0]     sum;
  logic                           a_ge_v;
  mau_pkg::mag_t                  diff;

  always_comb begin
    lo_byte = (field_left_i == '0) ? mau_pkg::FIELD_BITS'(1) : field_left_i;
    for (int b = 1; b <= mau_pkg::WORD_BYTES; b++) begin
      field_mask[(mau_pkg::WORD_BYTES-b)*mau_pkg::BYTE_BITS +: mau_pkg::BYTE_BITS] =
        ((mau_pkg::FIELD_BITS'(b) >= lo_byte) && (mau_pkg::FIELD_BITS'(b) <= field_right_i))
        ? {mau_pkg::BYTE_BITS{1'b1}} : '0;
    end
    shamt = mau_pkg::MAG_BITS'((mau_pkg::WORD_BYTES - int'(field_right_i))
                               * mau_pkg::BYTE_BITS);
    vm = (mem_mag_i & field_mask) >> shamt;
    vs = (field_left_i == '0) ? mem_sign_i : 1'b0;
    bad_field = (field_left_i > field_right_i) ||
                (field_right_i > mau_pkg::FIELD_BITS'(mau_pkg::WORD_BYTES));

    eff_sign = vs ^ (op_i == mau_pkg::OP_SUB);
    sum      = {1'b0, acc_mag_i} + {1'b0, vm};
    a_ge_v   = acc_mag_i >= vm;
    diff     = a_ge_v ? (acc_mag_i - vm) : (vm - acc_mag_i);

    cell_o        = '0;
    cell_o.mode   = mau_pkg::MODE_PASS;
    cell_o.hi     = acc_mag_i;
    cell_o.lo     = ext_mag_i;
    cell_o.v      = vm;
    cell_o.a_sign = acc_sign_i;
    cell_o.x_sign = ext_sign_i;
    cell_o.ovf    = 1'b0;

    if (bad_field) begin
      cell_o.ovf = 1'b1;
    end else begin
      case (op_i)
        mau_pkg::OP_ADD, mau_pkg::OP_SUB: begin
          if (acc_sign_i == eff_sign) begin
            cell_o.hi     = sum[mau_pkg::MAG_BITS-1:0];
            cell_o.a_sign = acc_sign_i && (sum != '0);
            cell_o.ovf    = sum[mau_pkg::MAG_BITS];
          end else begin
            cell_o.hi     = diff;
            cell_o.a_sign = (diff == '0) ? 1'b0 : (a_ge_v ? acc_sign_i : eff_sign);
          end
        end
        mau_pkg::OP_MUL: begin
          cell_o.mode   = mau_pkg::MODE_MUL;
          cell_o.hi     = '0;
          cell_o.lo     = acc_mag_i;
          cell_o.a_sign = acc_sign_i ^ vs;
          cell_o.x_sign = acc_sign_i ^ vs;
        end
        mau_pkg::OP_DIV: begin
          if ((vm == '0) || a_ge_v) begin
            cell_o.ovf = 1'b1;
          end else begin
            cell_o.mode   = mau_pkg::MODE_DIV;
            cell_o.a_sign = acc_sign_i ^ vs;
            cell_o.x_sign = acc_sign_i;
          end
        end
        default: cell_o.ovf = 1'b1;
      endcase
    end
  end

endmodule

@@ design/mau_cell.sv @@
// one pipeline cell: a stage register plus one shift-add, restoring-divide or pass-through step
// depends on mau_pkg
module mau_cell (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           valid_i,
  output logic           ready_o,
  input  mau_pkg::cell_t data_i,
  output logic           valid_o,
  input  logic           ready_i,
  output mau_pkg::cell_t data_o
);

  logic                       valid_q;
  mau_pkg::cell_t             data_q;
  logic [mau_pkg::MAG_BITS:0] acc;
  logic [mau_pkg::MAG_BITS:0] trial;
  logic [mau_pkg::MAG_BITS:0] rest;
  logic                       fits;

  assign ready_o = !valid_q || ready_i;
  assign valid_o = valid_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (ready_o) begin
      valid_q <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (ready_o && valid_i) begin
      data_q <= data_i;
    end
  end

  always_comb begin
    acc   = {1'b0, data_q.hi} + (data_q.lo[0] ? {1'b0, data_q.v} : '0);
    trial = {data_q.hi, data_q.lo[mau_pkg::MAG_BITS-1]};
    fits  = trial >= {1'b0, data_q.v};
    rest  = trial - {1'b0, data_q.v};
    data_o = data_q;
    case (data_q.mode)
      mau_pkg::MODE_MUL: begin
        data_o.hi = acc[mau_pkg::MAG_BITS:1];
        data_o.lo = {acc[0], data_q.lo[mau_pkg::MAG_BITS-1:1]};
      end
      mau_pkg::MODE_DIV: begin
        data_o.hi = fits ? rest[mau_pkg::MAG_BITS-1:0] : trial[mau_pkg::MAG_BITS-1:0];
        data_o.lo = {data_q.lo[mau_pkg::MAG_BITS-2:0], fits};
      end
      default: data_o = data_q;
    endcase
  end

endmodule

@@ design/mix_arithmetic_unit.sv @@
// top level of the mix arithmetic unit: front end, cell chain, output register
// depends on mau_pkg, mau_front, mau_cell and mix_arithmetic_unit_defines.svh
//
//  channel | direction | handshake              | payload
//  in      | input     | in_valid_i/in_ready_o  | op, field, A, X, memory word
//  out     | output    | out_valid_o/out_ready_i| new A, new X, overflow
//
// one transaction per cycle sustained while the output is not stalled; out_valid_o rises
// after acceptance, through MAG_BITS cell registers plus the output register, one cell per
// magnitude bit for the one-bit multiply/divide steps
// add, subtract and error cases ride the same chain unchanged
// reset empties every stage; a stalled output backs up only as far as the
// first empty stage, so inputs are taken while bubbles remain
`include "mix_arithmetic_unit_defines.svh"

module mix_arithmetic_unit (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          in_valid_i,
  output logic                          in_ready_o,
  input  logic [1:0]                    op_i,
  input  logic [mau_pkg::FIELD_BITS-1:0] field_left_i,
  input  logic [mau_pkg::FIELD_BITS-1:0] field_right_i,
  input  logic                          acc_sign_i,
  input  mau_pkg::mag_t                 acc_mag_i,
  input  logic                          ext_sign_i,
  input  mau_pkg::mag_t                 ext_mag_i,
  input  logic                          mem_sign_i,
  input  mau_pkg::mag_t                 mem_mag_i,
  output logic                          out_valid_o,
  input  logic                          out_ready_i,
  output logic                          new_acc_sign_o,
  output mau_pkg::mag_t                 new_acc_mag_o,
  output logic                          new_ext_sign_o,
  output mau_pkg::mag_t                 new_ext_mag_o,
  output logic                          overflow_set_o
);

  localparam int NCELLS = mau_pkg::MAG_BITS;

  mau_pkg::cell_t front_cell;
  mau_pkg::cell_t chain_data  [NCELLS+1];
  logic           chain_valid [NCELLS+1];
  logic           chain_ready [NCELLS+1];
  logic           out_valid_q;
  mau_pkg::cell_t out_q;

  mau_front u_front (
    .op_i         (op_i),
    .field_left_i (field_left_i),
    .field_right_i(field_right_i),
    .acc_sign_i   (acc_sign_i),
    .acc_mag_i    (acc_mag_i),
    .ext_sign_i   (ext_sign_i),
    .ext_mag_i    (ext_mag_i),
    .mem_sign_i   (mem_sign_i),
    .mem_mag_i    (mem_mag_i),
    .cell_o       (front_cell)
  );

  assign chain_data[0]  = front_cell;
  assign chain_valid[0] = in_valid_i;
  assign in_ready_o     = chain_ready[0];

  for (genvar k = 0; k < NCELLS; k++) begin : g_cell
    mau_cell u_cell (
      .clk_i  (clk_i),
      .rst_ni (rst_ni),
      .valid_i(chain_valid[k]),
      .ready_o(chain_ready[k]),
      .data_i (chain_data[k]),
      .valid_o(chain_valid[k+1]),
      .ready_i(chain_ready[k+1]),
      .data_o (chain_data[k+1])
    );
  end

  assign chain_ready[NCELLS] = !out_valid_q || out_ready_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (chain_ready[NCELLS]) begin
      out_valid_q <= chain_valid[NCELLS];
    end
  end

  always_ff @(posedge clk_i) begin
    if (chain_ready[NCELLS] && chain_valid[NCELLS]) begin
      out_q <= chain_data[NCELLS];
    end
  end

  // divide leaves the quotient in lo and the remainder in hi
  always_comb begin
    out_valid_o    = out_valid_q;
    new_acc_sign_o = out_q.a_sign;
    new_ext_sign_o = out_q.x_sign;
    overflow_set_o = out_q.ovf;
    case (out_q.mode)
      mau_pkg::MODE_DIV: begin
        new_acc_mag_o = out_q.lo;
        new_ext_mag_o = out_q.hi;
      end
      default: begin
        new_acc_mag_o = out_q.hi;
        new_ext_mag_o = out_q.lo;
      end
    endcase
  end

  `MAU_ASSERT_NOW(a_mul_no_ovf, out_valid_q && (out_q.mode == mau_pkg::MODE_MUL), !out_q.ovf, "multiply flagged overflow")
  `MAU_ASSERT_NOW(a_div_rem_lt, out_valid_q && (out_q.mode == mau_pkg::MODE_DIV), out_q.hi < out_q.v, "remainder not below divisor")
  `MAU_ASSERT_NOW(a_stall_full, !in_ready_o, chain_valid[1], "input stalled with empty first cell")
  `MAU_ASSERT_NEXT(a_out_load, chain_valid[NCELLS] && chain_ready[NCELLS], out_valid_q, "last cell result lost")

endmodule

@@ tb/tb_mix_arithmetic_unit.sv @@
// testbench for the mix arithmetic unit: random and directed instructions,
// results checked in order against a behavioural predictor; depends on mau_pkg
`timescale 1ns / 100ps

module tb_mix_arithmetic_unit;

  typedef struct packed {
    logic          a_s;
    mau_pkg::mag_t a_m;
    logic          x_s;
    mau_pkg::mag_t x_m;
    logic          ovf;
  } regs_t;

  class mix_scoreboard;
    regs_t pending[$];
    int    errors;

    function new();
      errors = 0;
    endfunction

    // note an accepted instruction and queue its predicted registers
    function void note_instr(logic [1:0] op, logic [2:0] lf, logic [2:0] rf, logic as,
                             mau_pkg::mag_t am, logic xs, mau_pkg::mag_t xm, logic ms,
                             mau_pkg::mag_t mm);
      regs_t         r;
      logic          vs;
      mau_pkg::mag_t vm;
      int            lo;
      logic [41:0]   s;
      logic          a_neg, v_neg;
      logic [79:0]   prod, dividend;
      mau_pkg::mag_t q, rm;
      r = '{as, am, xs, xm, 1'b1};
      if (lf > rf || rf > mau_pkg::WORD_BYTES) begin
        pending.push_back(r);
        return;
      end
      lo = (lf == 0) ? 1 : lf;
      vm = '0;
      if (rf >= lo) begin
        vm = mm >> ((mau_pkg::WORD_BYTES - rf) * mau_pkg::BYTE_BITS);
        vm = vm & mau_pkg::mag_t'((41'd1 << ((rf - lo + 1) * mau_pkg::BYTE_BITS)) - 41'd1);
      end
      vs = (lf == 0) ? ms : 1'b0;
      case (mau_pkg::op_e'(op))
        mau_pkg::OP_ADD, mau_pkg::OP_SUB: begin
          a_neg = as;
          v_neg = (op == mau_pkg::OP_SUB) ? ~vs : vs;
          if (a_neg == v_neg) begin
            s = {2'b0, am} + {2'b0, vm};
            r.a_s = (s == 0) ? 1'b0 : a_neg;
          end else if (am >= vm) begin
            s = {2'b0, am} - {2'b0, vm};
            r.a_s = (s == 0) ? 1'b0 : a_neg;
          end else begin
            s = {2'b0, vm} - {2'b0, am};
            r.a_s = v_neg;
          end
          r.a_m = s[mau_pkg::MAG_BITS-1:0];
          r.ovf = s[mau_pkg::MAG_BITS];
        end
        mau_pkg::OP_MUL: begin
          prod = {40'd0, am} * {40'd0, vm};
          r = '{as ^ vs, prod[79:40], as ^ vs, prod[39:0], 1'b0};
        end
        default: begin
          if (vm != 0 && am < vm) begin
            dividend = {am, xm};
            q = mau_pkg::mag_t'(dividend / {40'd0, vm});
            rm = mau_pkg::mag_t'(dividend % {40'd0, vm});
            r = '{as ^ vs, q, as, rm, 1'b0};
          end
        end
      endcase
      pending.push_back(r);
    endfunction

    function void check_result(regs_t got);
      regs_t e;
      if (pending.size() == 0) begin
        $error("result with nothing pending");
        errors++;
        return;
      end
      e = pending.pop_front();
      if (got.a_s !== e.a_s) begin
        $error("new_acc_sign exp %0h got %0h", e.a_s, got.a_s); errors++;
      end
      if (got.a_m !== e.a_m) begin
        $error("new_acc_mag exp %0h got %0h", e.a_m, got.a_m); errors++;
      end
      if (got.x_s !== e.x_s) begin
        $error("new_ext_sign exp %0h got %0h", e.x_s, got.x_s); errors++;
      end
      if (got.x_m !== e.x_m) begin
        $error("new_ext_mag exp %0h got %0h", e.x_m, got.x_m); errors++;
      end
      if (got.ovf !== e.ovf) begin
        $error("overflow_set exp %0h got %0h", e.ovf, got.ovf); errors++;
      end
    endfunction
  endclass

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  logic in_valid_i = 1'b0;
  logic in_ready_o;
  logic [1:0] op_i = '0;
  logic [2:0] field_left_i = '0, field_right_i = '0;
  logic acc_sign_i = 1'b0, ext_sign_i = 1'b0, mem_sign_i = 1'b0;
  mau_pkg::mag_t acc_mag_i = '0, ext_mag_i = '0, mem_mag_i = '0;
  logic out_valid_o;
  logic out_ready_i = 1'b0;
  logic new_acc_sign_o, new_ext_sign_o, overflow_set_o;
  mau_pkg::mag_t new_acc_mag_o, new_ext_mag_o;

  mix_scoreboard scb = new();
  bit   stall_long = 1'b0;

  always #6 clk_i = ~clk_i;

  mix_arithmetic_unit i_dut (.*);

  // ends the run if the handshakes hang
  initial begin
    #20ms;
    $display("Mismatches found");
    $finish;
  end

  function automatic mau_pkg::mag_t rand_mag();
    mau_pkg::mag_t m;
    m = mau_pkg::mag_t'({$urandom, $urandom});
    case ($urandom_range(0, 5))
      0: m = '0;
      1: m = '1;
      2: m = m >> $urandom_range(0, 39);
      default: ;
    endcase
    return m;
  endfunction

  // offer one transaction and hold it until accepted
  task automatic send_instr(logic [1:0] op, logic [2:0] lf, logic [2:0] rf, logic as,
                            mau_pkg::mag_t am, logic xs, mau_pkg::mag_t xm, logic ms,
                            mau_pkg::mag_t mm);
    in_valid_i <= 1'b1;
    op_i <= op; field_left_i <= lf; field_right_i <= rf;
    acc_sign_i <= as; acc_mag_i <= am; ext_sign_i <= xs; ext_mag_i <= xm;
    mem_sign_i <= ms; mem_mag_i <= mm;
    do @(posedge clk_i); while (!in_ready_o);
    scb.note_instr(op, lf, rf, as, am, xs, xm, ms, mm);
  endtask

  task automatic send_random(bit wild);
    logic [2:0] lf, rf;
    rf = wild ? 3'($urandom) : 3'($urandom_range(0, mau_pkg::WORD_BYTES));
    lf = wild ? 3'($urandom) : 3'($urandom_range(0, rf));
    send_instr(2'($urandom), lf, rf, 1'($urandom), rand_mag(), 1'($urandom), rand_mag(),
               1'($urandom), rand_mag());
  endtask

  task automatic idle_cycles(int n);
    if (n > 0) begin
      in_valid_i <= 1'b0;
      repeat (n) @(posedge clk_i);
    end
  endtask

  // receiver: own stall pattern plus one long hold-off counted here
  initial begin
    int k;
    int hold;
    k = 0;
    hold = 0;
    @(posedge rst_ni);
    forever begin
      @(posedge clk_i);
      if (out_valid_o && out_ready_i)
        scb.check_result('{new_acc_sign_o, new_acc_mag_o, new_ext_sign_o, new_ext_mag_o,
                           overflow_set_o});
      k++;
      if (stall_long) begin
        out_ready_i <= 1'b0;
        hold++;
        if (hold >= 150) stall_long = 1'b0;
      end
      else if ((k / 50) % 3 == 2) out_ready_i <= 1'b1;
      else out_ready_i <= ($urandom_range(0, 3) != 0);
    end
  end

  initial begin
    mau_pkg::mag_t top;
    top = '1;
    repeat (7) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    // directed: each op, field extremes, empty and invalid fields, zero divisor
    for (int op = 0; op < 4; op++) begin
      send_instr(2'(op), 3'd0, 3'd5, 1'b0, top, 1'b1, top, 1'b0, top);
      send_instr(2'(op), 3'd0, 3'd0, 1'b1, 40'd5, 1'b0, 40'd7, 1'b1, top);
      send_instr(2'(op), 3'd3, 3'd2, 1'b1, 40'd9, 1'b1, 40'd3, 1'b0, 40'd1);
      send_instr(2'(op), 3'd7, 3'd7, 1'b0, 40'd9, 1'b1, 40'd3, 1'b1, 40'd1);
      send_instr(2'(op), 3'd1, 3'd5, 1'b1, 40'd0, 1'b0, top, 1'b1, 40'd0);
    end
    send_instr(mau_pkg::OP_ADD, 3'd0, 3'd5, 1'b1, 40'd5, 1'b0, 40'd0, 1'b0, 40'd5);
    send_instr(mau_pkg::OP_SUB, 3'd0, 3'd5, 1'b0, 40'd5, 1'b0, 40'd0, 1'b0, 40'd5);
    send_instr(mau_pkg::OP_DIV, 3'd0, 3'd5, 1'b1, 40'd3, 1'b0, top, 1'b1, 40'd4);
    send_instr(mau_pkg::OP_DIV, 3'd5, 3'd5, 1'b0, 40'd0, 1'b1, 40'd1234, 1'b0, 40'd7);
    // long receiver hold-off while items keep coming
    stall_long = 1'b1;
    for (int i = 0; i < 80; i++) send_random(1'b0);
    in_valid_i <= 1'b0;
    // drain fully before bursts resume
    while (scb.pending.size() != 0) @(posedge clk_i);
    for (int i = 0; i < 520;) begin
      int burst;
      burst = $urandom_range(1, 30);
      for (int j = 0; j < burst; j++, i++) send_random($urandom_range(0, 9) == 0);
      idle_cycles(($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 12));
    end
    in_valid_i <= 1'b0;
    while (scb.pending.size() != 0) @(posedge clk_i);
    repeat (50) @(posedge clk_i);
    if (scb.errors == 0) $display("No mismatches found");
    else $display("Mismatches found");
    $finish;
  end
endmodule
